// ===== sv/timing_event_to_mil_telegram_gateway_defines.svh =====
// Assertion helpers for the checker file.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef TIMING_EVENT_TO_MIL_TELEGRAM_GATEWAY_DEFINES_SVH
`define TIMING_EVENT_TO_MIL_TELEGRAM_GATEWAY_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define GW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define GW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gw_pkg.sv =====
`timescale 1ns / 1ps

package gw_pkg;

    // Event filter and time correction
    localparam logic [31:0]        GW_TAG        = 32'h0000_0004;
    localparam logic signed [23:0] GW_LATENCY_NS = 24'sd73650;
    localparam logic signed [23:0] NO_OFFSET_NS  = 24'sd100000;
    localparam logic [21:0]        NS_PER_US     = 22'd1000;

    // Divider
    localparam int          DIVR_W      = 20;
    localparam logic [DIVR_W-1:0] NS_PER_MS = 20'd1000000;
    localparam logic [DIVR_W-1:0] MS_PER_S  = 20'd1000;
    localparam int          DIV_BITS    = 8;
    localparam int          DIV_STEPS   = 64 / DIV_BITS;
    localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);

    // UTC telegrams
    localparam logic [63:0] MS_AT_2008    = 64'd1199142000000;
    localparam int          MS_W          = 10;
    localparam int          SEC_W         = 30;
    localparam int          UTC_W         = MS_W + SEC_W;
    localparam int          N_UTC         = 5;
    localparam int          UTC_IDX_W     = 3;
    localparam logic [7:0]  UTC_CODE_BASE = 8'hE0;
    localparam logic [9:0]  GAP_BASE_NS   = 10'd96;
    localparam int          PAUSE_W       = 27;

    // Queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_LATENCY   = 3'd1,
        CFG_TRIG_CODE = 3'd2,
        CFG_TRIG_GAP  = 3'd3,
        CFG_UTC_GAP   = 3'd4
    } gw_cfg_idx_t;

    typedef struct packed {
        logic        enable;
        logic [11:0] latency_us;
        logic [7:0]  utc_trigger_code;
        logic [15:0] trigger_utc_gap;
        logic [15:0] utc_gap;
    } gw_cfg_t;

    localparam gw_cfg_t CFG_RESET = '{
        enable:           1'b0,
        latency_us:       12'd100,
        utc_trigger_code: 8'd0,
        trigger_utc_gap:  16'd0,
        utc_gap:          16'd0
    };

    // One accepted event waiting for the back end
    typedef struct packed {
        logic [15:0] telegram;
        logic [63:0] send_time;
        logic        utc_run;
    } gw_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } gw_q_stat_t;

    typedef struct packed {
        logic start;
        logic per_ms;
    } gw_div_ctl_t;

    typedef struct packed {
        logic              done;
        logic [63:0]       quotient;
        logic [DIVR_W-1:0] remainder;
    } gw_div_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV_NS,
        BK_DIV_MS,
        BK_UTC
    } gw_back_state_t;

    // 96 + 1024 * units
    function automatic logic [PAUSE_W-1:0] gap_ns(input logic [15:0] units);
        gap_ns = {1'b0, units, GAP_BASE_NS};
    endfunction

endpackage

// ===== sv/gw_evt_if.sv =====
`timescale 1ns / 1ps

interface gw_evt_if;
    logic        valid;
    logic        ready;
    logic [31:0] action_tag;
    logic        is_mil_event;
    logic [7:0]  event_code;
    logic [15:0] mil_word;
    logic [63:0] deadline_ns;

    modport source (
        output valid, action_tag, is_mil_event, event_code, mil_word, deadline_ns,
        input  ready
    );

    modport sink (
        input  valid, action_tag, is_mil_event, event_code, mil_word, deadline_ns,
        output ready
    );
endinterface

// ===== sv/gw_tlg_if.sv =====
`timescale 1ns / 1ps

interface gw_tlg_if;
    logic        valid;
    logic        ready;
    logic [15:0] telegram;
    logic [63:0] send_time_ns;
    logic [26:0] pause_before_ns;
    logic        last_word;

    modport source (
        output valid, telegram, send_time_ns, pause_before_ns, last_word,
        input  ready
    );

    modport sink (
        input  valid, telegram, send_time_ns, pause_before_ns, last_word,
        output ready
    );
endinterface

// ===== sv/gw_front.sv =====
`timescale 1ns / 1ps

module gw_front import gw_pkg::*; (
    input  gw_cfg_t    cfg,
    gw_evt_if.sink     evt,
    input  gw_q_stat_t q_stat,
    output logic       push,
    output gw_entry_t  push_data
);

    logic              keep;
    logic [21:0]       lat_ns;
    logic signed [23:0] offset_ns;

    // Filter: enabled gateway, timing tag, MIL-eligible event
    assign keep = cfg.enable && (evt.action_tag == GW_TAG) && evt.is_mil_event;

    // Every word is taken while the queue has room; dropped ones are not pushed
    assign evt.ready = !q_stat.full;
    assign push      = evt.valid && !q_stat.full && keep;

    // Corrected time: deadline + 73650 ns + (latency_us - 100) * 1000 ns, wrapping
    always_comb
    begin
        lat_ns    = 22'(cfg.latency_us) * NS_PER_US;
        offset_ns = $signed({2'b00, lat_ns}) + GW_LATENCY_NS - NO_OFFSET_NS;
        push_data.telegram  = evt.mil_word;
        push_data.send_time = evt.deadline_ns + {{40{offset_ns[23]}}, offset_ns};
        push_data.utc_run   = (evt.event_code == cfg.utc_trigger_code);
    end

endmodule

// ===== sv/gw_queue.sv =====
`timescale 1ns / 1ps

module gw_queue import gw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  gw_entry_t  push_data,
    input  logic       pop,
    output gw_entry_t  pop_data,
    output gw_q_stat_t q_stat
);

    gw_entry_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign q_stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (QUEUE_AW)'(push);
        rd_ptr_next = rd_ptr_reg + (QUEUE_AW)'(pop);
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/gw_div.sv =====
`timescale 1ns / 1ps

// 64-bit by 20-bit long division, DIV_BITS quotient bits per cycle
module gw_div import gw_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  gw_div_ctl_t  ctl,
    input  logic [63:0]  dividend,
    output gw_div_stat_t stat
);

    logic [63:0]          num_reg;
    logic [DIVR_W-1:0]    rem_reg;
    logic [DIVR_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [63:0]          step_num;
    logic [DIVR_W-1:0]    step_rem;
    logic [DIVR_W:0]      trial;
    logic [DIVR_W-1:0]    r;
    logic [63:0]          n;

    assign stat.done      = done_reg;
    assign stat.quotient  = num_reg;
    assign stat.remainder = rem_reg;

    // Restoring steps: dividend bits shift out the top, quotient bits in at the bottom
    always_comb
    begin
        r     = rem_reg;
        n     = num_reg;
        trial = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {r, n[63]};
            n     = {n[62:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                n[0]  = 1'b1;
            end
            r = trial[DIVR_W-1:0];
        end
        step_num = n;
        step_rem = r;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == (DIV_CNT_W)'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= ctl.per_ms ? MS_PER_S : NS_PER_MS;
        end
        else if (busy_reg)
        begin
            num_reg <= step_num;
            rem_reg <= step_rem;
        end
    end

endmodule

// ===== sv/gw_back.sv =====
`timescale 1ns / 1ps

module gw_back import gw_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  gw_cfg_t       cfg,
    input  gw_q_stat_t    q_stat,
    input  gw_entry_t     q_data,
    output logic          pop,
    output gw_div_ctl_t   div_ctl,
    output logic [63:0]   div_dividend,
    input  gw_div_stat_t  div_stat,
    gw_tlg_if.source      tlg
);

    gw_back_state_t        state_reg, state_next;

    logic                  tlg_valid_reg, tlg_valid_next;
    logic [15:0]           tlg_word_reg;
    logic [63:0]           tlg_time_reg;
    logic [PAUSE_W-1:0]    tlg_pause_reg;
    logic                  tlg_last_reg;

    logic [63:0]           time_reg;
    logic [UTC_W-1:0]      utc_reg;
    logic [UTC_IDX_W-1:0]  idx_reg;

    logic                  out_free;
    logic                  load_first;
    logic                  load_utc;
    logic                  capture_utc;
    logic                  idx_last;

    assign out_free = !tlg_valid_reg || tlg.ready;
    assign idx_last = (idx_reg == (UTC_IDX_W)'(N_UTC - 1));

    assign tlg.valid           = tlg_valid_reg;
    assign tlg.telegram        = tlg_word_reg;
    assign tlg.send_time_ns    = tlg_time_reg;
    assign tlg.pause_before_ns = tlg_pause_reg;
    assign tlg.last_word       = tlg_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && out_free && q_data.utc_run)
                begin
                    state_next = BK_DIV_NS;
                end
            end
            BK_DIV_NS:
            begin
                if (div_stat.done)
                begin
                    state_next = BK_DIV_MS;
                end
            end
            BK_DIV_MS:
            begin
                if (div_stat.done)
                begin
                    state_next = BK_UTC;
                end
            end
            BK_UTC:
            begin
                if (out_free && idx_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        pop            = 1'b0;
        load_first     = 1'b0;
        load_utc       = 1'b0;
        capture_utc    = 1'b0;
        div_ctl.start  = 1'b0;
        div_ctl.per_ms = 1'b0;
        div_dividend   = q_data.send_time;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop           = 1'b1;
                    load_first    = 1'b1;
                    div_ctl.start = q_data.utc_run;
                end
            end
            BK_DIV_NS:
            begin
                // ms since 2008, wrapping
                div_dividend   = div_stat.quotient - MS_AT_2008;
                div_ctl.per_ms = 1'b1;
                div_ctl.start  = div_stat.done;
            end
            BK_DIV_MS:
            begin
                capture_utc = div_stat.done;
            end
            BK_UTC:
            begin
                load_utc = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Output word valid
    always_comb
    begin
        tlg_valid_next = tlg_valid_reg && !tlg.ready;
        if (load_first || load_utc)
        begin
            tlg_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            tlg_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tlg_valid_reg <= tlg_valid_next;
            if (capture_utc)
            begin
                idx_reg <= '0;
            end
            else if (load_utc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Output word and run payload
    always_ff @(posedge clk)
    begin
        if (load_first)
        begin
            time_reg      <= q_data.send_time;
            tlg_word_reg  <= q_data.telegram;
            tlg_time_reg  <= q_data.send_time;
            tlg_pause_reg <= '0;
            tlg_last_reg  <= !q_data.utc_run;
        end
        else if (load_utc)
        begin
            tlg_word_reg  <= {utc_reg[UTC_W-1 -: 8], UTC_CODE_BASE + 8'(idx_reg)};
            tlg_time_reg  <= time_reg;
            tlg_pause_reg <= (idx_reg == '0) ? gap_ns(cfg.trigger_utc_gap)
                                             : gap_ns(cfg.utc_gap);
            tlg_last_reg  <= idx_last;
        end

        // {ms, seconds} is the five UTC bytes, most significant first
        if (capture_utc)
        begin
            utc_reg <= {div_stat.remainder[MS_W-1:0], div_stat.quotient[SEC_W-1:0]};
        end
        else if (load_utc)
        begin
            utc_reg <= {utc_reg[UTC_W-9:0], 8'h00};
        end
    end

endmodule

// ===== sv/timing_event_to_mil_telegram_gateway.sv =====
`timescale 1ns / 1ps

// Timing event to MIL telegram gateway. Each accepted event that passes the
// filter (gateway enabled, tag 4, MIL flag set) yields its telegram with the
// latency-corrected send time; if its code matches the UTC trigger, five UTC
// telegrams follow with their pauses. Events that do not pass are taken and
// dropped. Throughput: ordinary events flow at one word per cycle while the
// output accepts words. A UTC trigger event passes through the back end in
// order: its own word, which also loads the shared radix-256 divider, the ns
// to ms pass, the ms to seconds and ms fraction pass (reload plus eight
// steps), capture of the result and the five UTC words. A two-entry queue
// lets the input keep accepting while the back end is busy; the output word
// is registered, so a stall on the output side costs the front nothing until
// the queue fills. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module timing_event_to_mil_telegram_gateway import gw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    gw_evt_if.sink                evt,
    gw_tlg_if.source              tlg,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    gw_cfg_t      cfg_reg, cfg_next;
    gw_q_stat_t   q_stat;
    gw_entry_t    push_data;
    gw_entry_t    pop_data;
    logic         push;
    logic         pop;
    gw_div_ctl_t  div_ctl;
    gw_div_stat_t div_stat;
    logic [63:0]  div_dividend;

    // Configuration registers; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:    cfg_next.enable           = cfg_data[0];
                CFG_LATENCY:   cfg_next.latency_us       = cfg_data[11:0];
                CFG_TRIG_CODE: cfg_next.utc_trigger_code = cfg_data[7:0];
                CFG_TRIG_GAP:  cfg_next.trigger_utc_gap  = cfg_data;
                CFG_UTC_GAP:   cfg_next.utc_gap          = cfg_data;
                default:       cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gw_front u_front (
        .cfg       (cfg_reg),
        .evt       (evt),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    gw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    gw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .stat     (div_stat)
    );

    gw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_stat       (q_stat),
        .q_data       (pop_data),
        .pop          (pop),
        .div_ctl      (div_ctl),
        .div_dividend (div_dividend),
        .div_stat     (div_stat),
        .tlg          (tlg)
    );

endmodule

// ===== sv/gw_checker.sv =====
`timescale 1ns / 1ps
`include "timing_event_to_mil_telegram_gateway_defines.svh"

module gw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tlg_valid,
    input logic        tlg_ready,
    input logic [15:0] telegram,
    input logic [63:0] send_time_ns,
    input logic [26:0] pause_before_ns,
    input logic        last_word
);

    // Stalled word stays on the bus
    `GW_ASSERT_NEXT(a_hold_valid, tlg_valid && !tlg_ready, tlg_valid, "word lost while stalled")
    `GW_ASSERT_NEXT(a_hold_payload, tlg_valid && !tlg_ready, $stable(telegram) && $stable(send_time_ns) && $stable(pause_before_ns) && $stable(last_word), "word changed while stalled")

    // Pause is zero or 96 + 1024 * units
    `GW_ASSERT_SAME(a_pause_form, tlg_valid, pause_before_ns == 27'd0 || pause_before_ns[9:0] == 10'd96, "bad pause")

    // Words with a pause are UTC words, codes E0 to E4
    `GW_ASSERT_SAME(a_utc_code, tlg_valid && pause_before_ns != 27'd0, telegram[7:3] == 5'b11100 && telegram[2:0] <= 3'd4, "bad UTC code")

    // Last UTC word carries code E4
    `GW_ASSERT_SAME(a_utc_last, tlg_valid && pause_before_ns != 27'd0 && last_word, telegram[2:0] == 3'd4, "UTC run ends early")

endmodule

bind timing_event_to_mil_telegram_gateway gw_checker u_gw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .tlg_valid       (tlg.valid),
    .tlg_ready       (tlg.ready),
    .telegram        (tlg.telegram),
    .send_time_ns    (tlg.send_time_ns),
    .pause_before_ns (tlg.pause_before_ns),
    .last_word       (tlg.last_word)
);
